/* sv/reverb_microprogram_dsp_assert.svh */
// Assertion macros for the reverb DSP module.
// Each macro expects clk and rst_n in scope.
`ifndef REVERB_MICROPROGRAM_DSP_ASSERT_SVH
`define REVERB_MICROPROGRAM_DSP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rmd_pkg.sv */
package rmd_pkg;

    // default store sizes (powers of two)
    localparam int RAM_DEPTH_DEF = 16384;
    localparam int ROM_DEPTH_DEF = 32768;

    // program sequencing
    localparam int STEPS_PER_SAMPLE = 64;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_LAST        = 6'd63;
    localparam logic [STEP_W-1:0] RIGHT_LATCH_STEP = 6'd47;
    localparam logic [STEP_W-1:0] LEFT_LATCH_STEP  = 6'd56;
    localparam logic [STEP_W-1:0] LEFT_INPUT_STEP  = 6'd32;

    // widths
    localparam int SAMPLE_W   = 16;
    localparam int PAGE_W     = 7;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // input beat codes (tuser)
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_INDEX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAW_SELECT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_PROGRAM = 2'd2;

    // control byte bit positions
    localparam int CTL_SRC_INPUT = 0;  // write input sample instead of accumulator
    localparam int CTL_READ      = 1;  // 0: RAM write, 1: RAM read
    localparam int CTL_NO_LOAD   = 2;  // 0: load shifter
    localparam int CTL_INVERT    = 3;
    localparam int CTL_KEEP      = 4;  // 0: clear accumulator first

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_ADDR,
        ST_PH1,
        ST_PH2,
        ST_DONE
    } state_t;

    // controls for one accumulate phase
    typedef struct packed {
        logic keep;
        logic add;
        logic invert;
    } alu_ctl_t;

endpackage

/* sv/reverb_microprogram_dsp.sv */
// Sample beat: the 64 steps each run fetch, address, phase one and phase two, then the
// result is loaded into the output register; no input beat is taken until then, and the
// load waits while the previous result is still unread; a load beat leaves tready high.
// Step time is set by the single delay-RAM port and the shared accumulate unit
// (fetch, address, phase one, phase two).
// Reset: async active low; then a clearing pass zeroes every delay RAM word with
// tready low. Program store is not cleared.
`include "reverb_microprogram_dsp_assert.svh"

module reverb_microprogram_dsp #(
    parameter int RAM_DEPTH = rmd_pkg::RAM_DEPTH_DEF,
    parameter int ROM_DEPTH = rmd_pkg::ROM_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // rom_address[14:0], rom_byte[22:15], left_in[38:23], right_in[54:39], pad[55]
    input  logic [rmd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // cmd[0]
    input  logic                               s_axis_tuser,
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // left_out[15:0], right_out[31:16]
    output logic [rmd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [rmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rmd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int RAW        = $clog2(RAM_DEPTH);
    localparam int ROM_AW     = $clog2(ROM_DEPTH);
    localparam int ROM_ROW_W  = ROM_AW - 2;
    localparam int ROM_ROWS   = ROM_DEPTH / 4;
    localparam int ROW_FULL_W = rmd_pkg::PAGE_W + rmd_pkg::STEP_W;
    localparam logic [RAW-1:0] RAM_LAST = RAW'(RAM_DEPTH - 1);

    // state and datapath registers
    rmd_pkg::state_t              state_reg, state_next;
    logic [rmd_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [RAW-1:0]               clr_reg, clr_next;
    logic [RAW-1:0]               pos_reg, pos_next;
    logic [RAW-1:0]               ra_reg, ra_next;
    logic signed [15:0]           acc_reg, acc_next;
    logic signed [15:0]           shift_reg, shift_next;
    logic                         carry_reg, carry_next;
    logic signed [15:0]           left_h_reg, left_h_next;
    logic signed [15:0]           right_h_reg, right_h_next;
    logic signed [15:0]           rout_reg, rout_next;
    logic signed [15:0]           lout_reg, lout_next;
    logic                         out_valid_reg, out_valid_next;
    logic [rmd_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [15:0]                  ram_q_reg;

    // configuration
    logic [rmd_pkg::PAGE_W-1:0]   prog_idx_reg;
    logic [1:0]                   saw_reg;
    logic                         ext_reg;

    // memories
    logic [15:0]                  ram_mem [RAM_DEPTH];
    logic [7:0]                   rom_q [4];

    // decode of the current step word
    logic                         accept;
    logic                         rom_we;
    logic [1:0]                   rom_wlane;
    logic [ROM_ROW_W-1:0]         rom_wrow;
    logic [rmd_pkg::PAGE_W-1:0]   page;
    logic [ROW_FULL_W-1:0]        row_full;
    logic [ROM_ROW_W-1:0]         rom_rrow;
    logic [7:0]                   ctl1, ctl2, b0, b2;
    logic [15:0]                  offset;
    logic [RAW-1:0]               ra_calc;
    logic signed [15:0]           step_data;
    logic signed [15:0]           wr_val;
    logic                         do_load;
    logic                         do_write;
    logic                         ram_we;
    logic [RAW-1:0]               ram_waddr;
    logic [15:0]                  ram_wdata;
    logic [7:0]                   alu_byte;
    logic [3:0]                   alu_mask;
    logic                         alu_carry;
    rmd_pkg::alu_ctl_t            alu_ctl;
    logic signed [15:0]           alu_out;

    // handshake
    assign s_axis_tready = (state_reg == rmd_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // program store write side: four byte lanes, one word per row
    assign rom_we    = accept && (s_axis_tuser == rmd_pkg::CMD_LOAD);
    assign rom_wlane = s_axis_tdata[1:0];
    assign rom_wrow  = s_axis_tdata[ROM_AW-1:2];

    // program store read row: page then step
    assign page     = ext_reg ? prog_idx_reg : {1'b0, prog_idx_reg[5:0]};
    assign row_full = {page, step_reg};
    assign rom_rrow = row_full[ROM_ROW_W-1:0];

    for (genvar g = 0; g < 4; g++)
    begin : g_rom_lane
        logic [7:0] lane_mem [ROM_ROWS];
        logic [7:0] rom_byte_reg;

        always_ff @(posedge clk)
        begin
            if (rom_we && (rom_wlane == 2'(g)))
            begin
                lane_mem[rom_wrow] <= s_axis_tdata[22:15];
            end
            if (state_reg == rmd_pkg::ST_FETCH)
            begin
                rom_byte_reg <= lane_mem[rom_rrow];
            end
        end

        assign rom_q[g] = rom_byte_reg;
    end

    // step word fields
    assign b0     = rom_q[0];
    assign ctl1   = rom_q[1];
    assign b2     = rom_q[2];
    assign ctl2   = rom_q[3];
    assign offset = {b2, b0};
    assign ra_calc = pos_reg + offset[RAW-1:0];

    // phase one delay-RAM action
    assign step_data = (step_reg < rmd_pkg::LEFT_INPUT_STEP) ? right_h_reg : left_h_reg;
    assign wr_val    = ctl1[rmd_pkg::CTL_SRC_INPUT] ? step_data : acc_reg;
    assign do_load   = !ctl1[rmd_pkg::CTL_NO_LOAD];
    assign do_write  = !ctl1[rmd_pkg::CTL_READ];

    // delay RAM port: clearing pass or phase one write
    always_comb
    begin
        ram_we    = (state_reg == rmd_pkg::ST_CLEAR) ||
                    ((state_reg == rmd_pkg::ST_PH1) && do_write);
        ram_waddr = (state_reg == rmd_pkg::ST_CLEAR) ? clr_reg : ra_reg;
        ram_wdata = (state_reg == rmd_pkg::ST_CLEAR) ? 16'd0 : wr_val;
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[ram_waddr] <= ram_wdata;
        end
        if (state_reg == rmd_pkg::ST_ADDR)
        begin
            ram_q_reg <= ram_mem[ra_calc];
        end
    end

    // shared accumulate unit operands
    always_comb
    begin
        if (state_reg == rmd_pkg::ST_PH1)
        begin
            alu_byte  = ctl1;
            alu_mask  = {ctl1[7:5], b2[7]};
            alu_carry = do_load ? 1'b0 : carry_reg;
        end
        else
        begin
            alu_byte  = ctl2;
            alu_mask  = {ctl2[7:5], b2[6]};
            alu_carry = carry_reg;
        end
        alu_ctl.keep   = alu_byte[rmd_pkg::CTL_KEEP];
        alu_ctl.add    = alu_mask[saw_reg];
        alu_ctl.invert = alu_byte[rmd_pkg::CTL_INVERT];
    end

    rmd_alu u_alu (
        .acc    (acc_reg),
        .shift  (shift_reg),
        .carry  (alu_carry),
        .ctl    (alu_ctl),
        .result (alu_out)
    );

    // sequencer next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        ra_next        = ra_reg;
        acc_next       = acc_reg;
        shift_next     = shift_reg;
        carry_next     = carry_reg;
        left_h_next    = left_h_reg;
        right_h_next   = right_h_reg;
        rout_next      = rout_reg;
        lout_next      = lout_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rmd_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == RAM_LAST)
                begin
                    state_next = rmd_pkg::ST_IDLE;
                end
            end
            rmd_pkg::ST_IDLE:
            begin
                if (accept && (s_axis_tuser == rmd_pkg::CMD_SAMPLE))
                begin
                    left_h_next  = $signed(s_axis_tdata[38:23]) >>> 1;
                    right_h_next = $signed(s_axis_tdata[54:39]) >>> 1;
                    state_next   = rmd_pkg::ST_FETCH;
                end
            end
            rmd_pkg::ST_FETCH:
            begin
                // outputs are taken before the latch steps run
                if (step_reg == rmd_pkg::RIGHT_LATCH_STEP)
                begin
                    rout_next = acc_reg;
                end
                if (step_reg == rmd_pkg::LEFT_LATCH_STEP)
                begin
                    lout_next = acc_reg;
                end
                state_next = rmd_pkg::ST_ADDR;
            end
            rmd_pkg::ST_ADDR:
            begin
                ra_next    = ra_calc;
                state_next = rmd_pkg::ST_PH1;
            end
            rmd_pkg::ST_PH1:
            begin
                acc_next = alu_out;
                if (do_load)
                begin
                    shift_next = do_write ? wr_val : $signed(ram_q_reg);
                    carry_next = 1'b0;
                end
                else
                begin
                    shift_next = shift_reg >>> 1;
                    carry_next = shift_reg[15] & shift_reg[0];
                end
                state_next = rmd_pkg::ST_PH2;
            end
            rmd_pkg::ST_PH2:
            begin
                acc_next   = alu_out;
                carry_next = shift_reg[15] & shift_reg[0];
                shift_next = shift_reg >>> 1;
                step_next  = step_reg + 1'b1;
                state_next = (step_reg == rmd_pkg::STEP_LAST) ? rmd_pkg::ST_DONE
                                                              : rmd_pkg::ST_FETCH;
            end
            rmd_pkg::ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {rout_reg, lout_reg};
                    pos_next       = pos_reg + 1'b1;
                    state_next     = rmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmd_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmd_pkg::ST_CLEAR;
            step_reg      <= '0;
            clr_reg       <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            shift_reg     <= '0;
            carry_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            shift_reg     <= shift_next;
            carry_reg     <= carry_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ra_reg       <= ra_next;
        left_h_reg   <= left_h_next;
        right_h_reg  <= right_h_next;
        rout_reg     <= rout_next;
        lout_reg     <= lout_next;
        out_data_reg <= out_data_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_idx_reg <= '0;
            saw_reg      <= '0;
            ext_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rmd_pkg::CFG_PROGRAM_INDEX:    prog_idx_reg <= cfg_data;
                rmd_pkg::CFG_SAW_SELECT:       saw_reg      <= cfg_data[1:0];
                rmd_pkg::CFG_EXTENDED_PROGRAM: ext_reg      <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // checks
    `RMD_ASSERT_NEXT(a_sample_busy, accept && (s_axis_tuser == rmd_pkg::CMD_SAMPLE), !s_axis_tready, "sample beat did not stall input")
    `RMD_ASSERT_NOW(a_idle_step, state_reg == rmd_pkg::ST_IDLE, step_reg == '0, "step counter not at zero when idle")
    `RMD_ASSERT_NEXT(a_step_loop, (state_reg == rmd_pkg::ST_PH2) && (step_reg != rmd_pkg::STEP_LAST), state_reg == rmd_pkg::ST_FETCH, "step did not loop to fetch")
    `RMD_ASSERT_NEXT(a_out_load, (state_reg == rmd_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready), out_valid_reg && (state_reg == rmd_pkg::ST_IDLE), "result not loaded at end of sample")

endmodule

/* sv/rmd_alu.sv */
// Saturating accumulate unit, shared by both phases of every step.
module rmd_alu (
    input  logic signed [15:0] acc,
    input  logic signed [15:0] shift,
    input  logic               carry,
    input  rmd_pkg::alu_ctl_t  ctl,
    output logic signed [15:0] result
);

    logic signed [15:0] base;
    logic signed [17:0] sum;
    logic signed [15:0] sat;
    logic signed [15:0] added;

    // optional clear, then add with carry in 18 bits
    always_comb
    begin
        base = ctl.keep ? acc : 16'sd0;
        sum  = {{2{base[15]}}, base} + {{2{shift[15]}}, shift} + {17'd0, carry};
    end

    // clamp to 16-bit range
    always_comb
    begin
        if (!sum[17] && (sum[16:15] != 2'b00))
        begin
            sat = 16'sh7fff;
        end
        else if (sum[17] && (sum[16:15] != 2'b11))
        begin
            sat = 16'sh8000;
        end
        else
        begin
            sat = sum[15:0];
        end
    end

    // inversion applies whether or not an add took place
    always_comb
    begin
        added  = ctl.add ? sat : base;
        result = ctl.invert ? ~added : added;
    end

endmodule

/* tb/reverb_output_checker.sv */
// Watches the stream and config ports of the reverb DSP, predicts every
// sample beat's stereo result and compares it with the returned beats.
module reverb_output_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // rom_address[14:0], rom_byte[22:15], left_in[38:23], right_in[54:39], pad[55]
    input  logic [rmd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // cmd[0]
    input  logic                               s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // left_out[15:0], right_out[31:16]
    input  logic [rmd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [rmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 mismatch_count,
    output int                                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rmd_pkg::*;

    localparam int ECHO_DEPTH = RAM_DEPTH_DEF;
    localparam int CODE_DEPTH = ROM_DEPTH_DEF;
    localparam int ACC_MAX    = 32767;
    localparam int ACC_MIN    = -32768;

    typedef struct packed {
        logic signed [15:0] right_out;
        logic signed [15:0] left_out;
    } stereo_out_t;

    // predictor state
    logic [15:0]  echo_ram [ECHO_DEPTH];
    logic [7:0]   microcode [CODE_DEPTH];
    int           acc;
    int           shifter;
    int           carry;
    int           position;
    logic [6:0]   page_reg;
    logic [1:0]   saw_sel;
    logic         ext_prog;

    stereo_out_t  expected_outputs[$];
    stereo_out_t  want;
    stereo_out_t  got;
    int           fails;

    // one accumulate phase: optional clear, masked saturating add, inversion
    task automatic mix_phase(input logic [7:0] ctl, input logic [3:0] mask);
        int sum;
        if (!ctl[CTL_KEEP])
            acc = 0;
        if (mask[saw_sel])
        begin
            sum = acc + shifter + carry;
            if (sum < ACC_MIN)
                sum = ACC_MIN;
            else if (sum > ACC_MAX)
                sum = ACC_MAX;
            acc = sum;
        end
        if (ctl[CTL_INVERT])
            acc = -acc - 1;
    endtask

    // one program step: delay access, then two accumulate phases
    task automatic run_step(input int step, input int sample);
        logic [6:0] page;
        int         base;
        logic [7:0] off_lo;
        logic [7:0] ctl1;
        logic [7:0] off_hi;
        logic [7:0] ctl2;
        int         addr;
        int         next_shift;
        int         next_carry;
        int         v;
        page = ext_prog ? page_reg : {1'b0, page_reg[5:0]};
        base = (int'(page) << 8) + step * 4;
        off_lo = microcode[base];
        ctl1   = microcode[base + 1];
        off_hi = microcode[base + 2];
        ctl2   = microcode[base + 3];
        addr = (position + int'({off_hi, off_lo})) % ECHO_DEPTH;
        next_shift = shifter >>> 1;
        next_carry = (shifter < 0) ? (shifter & 1) : 0;

        if (!ctl1[CTL_READ])
        begin
            v = ctl1[CTL_SRC_INPUT] ? sample : acc;
            echo_ram[addr] = v[15:0];
            if (!ctl1[CTL_NO_LOAD])
            begin
                next_shift = v;
                carry = 0;
                next_carry = 0;
            end
        end
        else if (!ctl1[CTL_NO_LOAD])
        begin
            next_shift = int'($signed(echo_ram[addr]));
            carry = 0;
            next_carry = 0;
        end

        mix_phase(ctl1, {ctl1[7:5], off_hi[7]});
        carry = next_carry;
        shifter = next_shift;
        mix_phase(ctl2, {ctl2[7:5], off_hi[6]});
        carry = (shifter < 0) ? (shifter & 1) : 0;
        shifter = shifter >>> 1;
    endtask

    // full program pass for one stereo sample
    task automatic run_program(input int left_half, input int right_half,
                               output stereo_out_t res);
        int lout;
        int rout;
        lout = 0;
        rout = 0;
        for (int s = 0; s < STEPS_PER_SAMPLE; s++)
        begin
            if (s == int'(RIGHT_LATCH_STEP))
                rout = acc;
            else if (s == int'(LEFT_LATCH_STEP))
                lout = acc;
            run_step(s, (s < int'(LEFT_INPUT_STEP)) ? right_half : left_half);
        end
        position = (position + 1) % ECHO_DEPTH;
        res.left_out  = lout[15:0];
        res.right_out = rout[15:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ECHO_DEPTH; i++)
                echo_ram[i] = '0;
            acc = 0;
            shifter = 0;
            carry = 0;
            position = 0;
            page_reg = '0;
            saw_sel = '0;
            ext_prog = 1'b1;
            expected_outputs.delete();
            fails = 0;
            mismatch_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = stereo_out_t'(m_axis_tdata);
                if (expected_outputs.size() == 0)
                begin
                    $error("unexpected result beat: left_out %0d right_out %0d",
                           got.left_out, got.right_out);
                    fails++;
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (got.left_out !== want.left_out)
                    begin
                        $error("left_out: expected %0d, actual %0d",
                               want.left_out, got.left_out);
                        fails++;
                    end
                    if (got.right_out !== want.right_out)
                    begin
                        $error("right_out: expected %0d, actual %0d",
                               want.right_out, got.right_out);
                        fails++;
                    end
                end
            end

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROGRAM_INDEX:    page_reg = cfg_data[6:0];
                    CFG_SAW_SELECT:       saw_sel  = cfg_data[1:0];
                    CFG_EXTENDED_PROGRAM: ext_prog = cfg_data[0];
                    default: ;
                endcase
            end

            // input beat: program byte load or sample
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == CMD_LOAD)
                    microcode[s_axis_tdata[14:0]] = s_axis_tdata[22:15];
                else
                begin
                    run_program(int'($signed(s_axis_tdata[38:23])) >>> 1,
                                int'($signed(s_axis_tdata[54:39])) >>> 1, want);
                    expected_outputs.push_back(want);
                end
            end

            mismatch_count <= fails;
            outstanding <= expected_outputs.size();
        end
    end

endmodule

/* tb/reverb_microprogram_dsp_tb.sv */
module reverb_microprogram_dsp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmd_pkg::*;

    localparam int PAGE_BYTES = 256;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = CMD_LOAD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_PROGRAM_INDEX;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatch_count;
    int outstanding;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;

    always #1 clk = ~clk;

    reverb_microprogram_dsp i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    reverb_output_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // receiver backpressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // one input beat, with a random gap in front of it
    task automatic send_beat(input logic cmd, input logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // unused sample fields carry random bits
    task automatic load_byte(input logic [14:0] addr, input logic [7:0] val);
        logic [15:0] junk_l;
        logic [15:0] junk_r;
        junk_l = $urandom;
        junk_r = $urandom;
        send_beat(CMD_LOAD, {1'b0, junk_r, junk_l, val, addr});
    endtask

    task automatic send_sample(input logic [15:0] left, input logic [15:0] right);
        logic [14:0] junk_addr;
        logic [7:0]  junk_byte;
        junk_addr = $urandom;
        junk_byte = $urandom;
        send_beat(CMD_SAMPLE, {1'b0, right, left, junk_byte, junk_addr});
    endtask

    // step-word byte; offset high byte mostly keeps the low 6 bits clear so that
    // reads land near recently written delay taps
    function automatic logic [7:0] program_byte(input logic [1:0] lane);
        logic [7:0] b;
        b = $urandom;
        if (lane == 2'd2 && $urandom_range(3) != 0)
            b[5:0] = '0;
        return b;
    endfunction

    function automatic logic [15:0] audio_value();
        case ($urandom_range(15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_page(input logic [6:0] page);
        for (int i = 0; i < PAGE_BYTES; i++)
            load_byte({page, 8'(i)}, program_byte(2'(i)));
    endtask

    // stop sending and wait for every predicted result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // unused register bits and the unused index get random values
    task automatic configure(input logic [6:0] page_sel, input logic [1:0] saw,
                             input logic ext);
        logic [4:0] saw_hi;
        logic [5:0] ext_hi;
        saw_hi = $urandom;
        ext_hi = $urandom;
        write_reg(CFG_UNUSED, 7'($urandom_range(127)));
        write_reg(CFG_PROGRAM_INDEX, page_sel);
        write_reg(CFG_SAW_SELECT, {saw_hi, saw});
        write_reg(CFG_EXTENDED_PROGRAM, {ext_hi, ext});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly samples, some program rewrites in the live page or elsewhere
    task automatic random_items(input int count, input logic [6:0] page);
        logic [7:0] offset;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(49) == 0)
                drain();
            if ($urandom_range(99) < 85)
                send_sample(audio_value(), audio_value());
            else if ($urandom_range(9) < 4)
            begin
                offset = $urandom;
                load_byte({page, offset}, program_byte(offset[1:0]));
            end
            else
                load_byte(15'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        logic [15:0] dir_left[10];
        logic [15:0] dir_right[10];
        logic [6:0]  mid_page;

        dir_left  = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                      16'hFFFF, 16'h0001, 16'hFFFF, 16'h4000, 16'h5555};
        dir_right = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                      16'h0001, 16'hFFFF, 16'hFFFF, 16'hBFFF, 16'hAAAA};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // delay RAM clearing pass holds tready low
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);

        snd_idle_pct = 23;
        rcv_idle_pct = 62;

        // page 0, lowest settings
        configure(7'd0, 2'd0, 1'b1);
        load_page(7'd0);
        load_byte(15'h0000, 8'h00);
        load_byte(15'h7FFF, 8'hFF);
        for (int i = 0; i < 10; i++)
            send_sample(dir_left[i], dir_right[i]);
        random_items(180, 7'd0);

        // top page, highest saw bit
        drain();
        configure(7'd127, 2'd3, 1'b1);
        load_page(7'd127);
        random_items(180, 7'd127);

        // short program store: index 127 folds onto page 63
        drain();
        snd_idle_pct = 62;
        rcv_idle_pct = 23;
        configure(7'd127, 2'd1, 1'b0);
        load_page(7'd63);
        random_items(180, 7'd63);

        drain();
        mid_page = 7'($urandom_range(62, 1));
        configure(mid_page | 7'd64, 2'd2, 1'b0);
        load_page(mid_page);
        random_items(180, mid_page);

        // back to page 0 with no idling
        drain();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        configure(7'd0, 2'($urandom_range(3)), 1'b1);
        random_items(250, 7'd0);

        drain();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
